### design/tbb_pkg.sv
// tbb_pkg: shared constants of the tile bounding box builder
// no dependencies; used by the channel interfaces and the core

package tbb_pkg;

	// widths fixed by the stream fields
	localparam int TYPE_BITS  = 3;
	localparam int FIELD_BITS = 32;
	localparam int TYPE_COUNT = 6;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;
	localparam int MASK_BITS      = 6;
	localparam int SIZE_BITS      = 16;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_TYPE_MASK = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_SIZE = 1'd1;

	localparam logic [MASK_BITS-1:0] TYPE_MASK_RESET = 6'd63;
	localparam logic [SIZE_BITS-1:0] TILE_SIZE_RESET = 16'd32;

endpackage

### design/tbb_particle_if.sv
// tbb_particle_if: valid/ready channel carrying one particle per transfer
// depends on tbb_pkg for field widths

interface tbb_particle_if;
	logic                                  valid;
	logic                                  ready;
	logic        [tbb_pkg::TYPE_BITS-1:0]  particle_type;
	logic signed [tbb_pkg::FIELD_BITS-1:0] particle_mass;
	logic signed [tbb_pkg::FIELD_BITS-1:0] position_x;
	logic signed [tbb_pkg::FIELD_BITS-1:0] position_y;
	logic signed [tbb_pkg::FIELD_BITS-1:0] position_z;
	logic        [tbb_pkg::FIELD_BITS-1:0] kernel_radius;
	logic                                  last_particle;

	modport source (
		output valid, particle_type, particle_mass, position_x, position_y, position_z,
		output kernel_radius, last_particle,
		input  ready
	);
	modport sink (
		input  valid, particle_type, particle_mass, position_x, position_y, position_z,
		input  kernel_radius, last_particle,
		output ready
	);
endinterface

### design/tbb_tile_if.sv
// tbb_tile_if: valid/ready channel carrying one tile record per transfer
// depends on tbb_pkg for field widths

interface tbb_tile_if #(
	parameter int POOL_BITS  = 24,
	parameter int COUNT_BITS = 16
);
	logic                                  valid;
	logic                                  ready;
	logic        [POOL_BITS-1:0]           tile_first;
	logic        [COUNT_BITS-1:0]          tile_count;
	logic signed [tbb_pkg::FIELD_BITS-1:0] low_x;
	logic signed [tbb_pkg::FIELD_BITS-1:0] low_y;
	logic signed [tbb_pkg::FIELD_BITS-1:0] low_z;
	logic signed [tbb_pkg::FIELD_BITS-1:0] high_x;
	logic signed [tbb_pkg::FIELD_BITS-1:0] high_y;
	logic signed [tbb_pkg::FIELD_BITS-1:0] high_z;
	logic        [tbb_pkg::FIELD_BITS-1:0] radius_max;
	logic                                  last_tile;
	logic        [POOL_BITS-1:0]           accepted_total;

	modport source (
		output valid, tile_first, tile_count, low_x, low_y, low_z, high_x, high_y, high_z,
		output radius_max, last_tile, accepted_total,
		input  ready
	);
	modport sink (
		input  valid, tile_first, tile_count, low_x, low_y, low_z, high_x, high_y, high_z,
		input  radius_max, last_tile, accepted_total,
		output ready
	);
endinterface

### design/tile_bounding_box_builder_core.sv
// tile_bounding_box_builder_core: top level of the tile bounding box builder
// depends on tbb_pkg, tbb_particle_if, tbb_tile_if and tbb_box_update

// Takes curve-ordered particles, one per transfer, and groups the admitted ones
// (type bit set in type_mask, mass strictly positive) into tiles of tile_size
// particles, keeping per-axis min/max position and the largest kernel radius.
// A tile record goes out when a tile fills, or on the last particle while a
// partial tile is open; that record has last_tile set and accepted_total holds
// the stream total (saturating). An empty stream emits nothing. Throughput is
// one particle per cycle: a particle is registered in the input stage, where
// the compares against the running box update the tile state, and its record,
// if any, lands in the output register once that register is free. The
// input stage keeps taking particles while a record waits in the output
// register; only when both are occupied and the sink stalls does ready drop.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// between streams; the block itself does not enforce this. A tile_size of
// zero acts as one and sizes beyond the fill counter are capped at its maximum.

module tile_bounding_box_builder_core #(
	parameter int COORD_BITS = 32,
	parameter int COUNT_BITS = 16,
	parameter int POOL_BITS  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tbb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tbb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	tbb_particle_if.sink                        particles,
	tbb_tile_if.source                          tiles
);
	// internal coordinate width, at most what the fields carry
	localparam int FW = tbb_pkg::FIELD_BITS;
	localparam int CW = (COORD_BITS < FW) ? COORD_BITS : FW;
	localparam int TW = tbb_pkg::TYPE_BITS;
	// width for comparing fill against the size register
	localparam int SW = (COUNT_BITS > tbb_pkg::SIZE_BITS) ? COUNT_BITS : tbb_pkg::SIZE_BITS;

	// configuration registers
	logic [tbb_pkg::MASK_BITS-1:0] type_mask_q;
	logic [tbb_pkg::SIZE_BITS-1:0] tile_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_mask_q <= tbb_pkg::TYPE_MASK_RESET;
			tile_size_q <= tbb_pkg::TILE_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tbb_pkg::CFG_TYPE_MASK: type_mask_q <= cfg_data[tbb_pkg::MASK_BITS-1:0];
				tbb_pkg::CFG_TILE_SIZE: tile_size_q <= cfg_data[tbb_pkg::SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective tile size: zero acts as one, capped at the fill counter maximum
	logic [SW-1:0] size_wide;
	logic [SW-1:0] size_cap;
	logic [SW-1:0] size_eff;

	assign size_wide = SW'(tile_size_q);
	assign size_cap  = SW'({COUNT_BITS{1'b1}});
	always_comb begin
		if (tile_size_q == '0) begin
			size_eff = SW'(1);
		end else if (size_wide > size_cap) begin
			size_eff = size_cap;
		end else begin
			size_eff = size_wide;
		end
	end

	// output register handshake
	logic out_valid_q;
	logic out_free;
	logic valid_s1;
	logic adv_s1;

	assign out_free        = !out_valid_q || tiles.ready;
	assign adv_s1          = valid_s1 && out_free;
	assign particles.ready = !valid_s1 || out_free;

	// input stage
	logic        [tbb_pkg::TYPE_BITS-1:0] type_s1;
	logic signed [FW-1:0]                 mass_s1;
	logic signed [CW-1:0]                 pos_s1 [3];
	logic        [CW-1:0]                 rad_s1;
	logic                                 last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (particles.ready) begin
			valid_s1 <= particles.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (particles.ready && particles.valid) begin
			type_s1   <= particles.particle_type;
			mass_s1   <= particles.particle_mass;
			pos_s1[0] <= particles.position_x[CW-1:0];
			pos_s1[1] <= particles.position_y[CW-1:0];
			pos_s1[2] <= particles.position_z[CW-1:0];
			rad_s1    <= particles.kernel_radius[CW-1:0];
			last_s1   <= particles.last_particle;
		end
	end

	// tile state
	logic        [POOL_BITS-1:0]  acc_q;
	logic        [POOL_BITS-1:0]  start_q;
	logic        [COUNT_BITS-1:0] fill_q;
	logic        [CW-1:0]         radius_q;
	logic signed [CW-1:0]         low_q  [3];
	logic signed [CW-1:0]         high_q [3];

	// admission of the staged particle
	logic type_ok;
	logic mass_ok;
	logic admit;
	logic first;

	assign type_ok = (type_s1 < TW'(tbb_pkg::TYPE_COUNT))
		? type_mask_q[type_s1] : 1'b0;
	assign mass_ok = (mass_s1 != '0) && !mass_s1[FW-1];
	assign admit   = valid_s1 && type_ok && mass_ok;
	assign first   = (fill_q == '0);

	// box and radius after folding in the staged particle
	logic signed [CW-1:0] low_n  [3];
	logic signed [CW-1:0] high_n [3];
	logic        [CW-1:0] radius_n;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		tbb_box_update #(
			.W(CW)
		) u_axis (
			.first     (first),
			.pos       (pos_s1[a]),
			.low       (low_q[a]),
			.high      (high_q[a]),
			.low_next  (low_n[a]),
			.high_next (high_n[a])
		);
	end

	assign radius_n = (first || rad_s1 > radius_q) ? rad_s1 : radius_q;

	// counters
	logic [COUNT_BITS-1:0] fill_n;
	logic [POOL_BITS-1:0]  acc_n;
	logic                  full;
	logic                  emit;

	assign fill_n = fill_q + COUNT_BITS'(1);
	assign acc_n  = (acc_q != '1) ? acc_q + POOL_BITS'(1) : acc_q;
	assign full   = admit && (SW'(fill_n) >= size_eff);
	// full tile, or stream end with a partial tile open
	assign emit   = full || (valid_s1 && last_s1 && (admit || !first));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			start_q  <= '0;
			fill_q   <= '0;
			radius_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// stream closes: counters return to zero
				acc_q    <= '0;
				start_q  <= '0;
				fill_q   <= '0;
				radius_q <= '0;
			end else if (full) begin
				acc_q    <= acc_n;
				start_q  <= start_q + POOL_BITS'(fill_n);
				fill_q   <= '0;
				radius_q <= radius_n;
			end else if (admit) begin
				acc_q    <= acc_n;
				fill_q   <= fill_n;
				radius_q <= radius_n;
			end
		end
	end

	// box registers are always opened by a tile's first particle
	always_ff @(posedge clk) begin
		if (adv_s1 && admit) begin
			for (int a = 0; a < 3; a++) begin
				low_q[a]  <= low_n[a];
				high_q[a] <= high_n[a];
			end
		end
	end

	// output register
	logic        [COUNT_BITS-1:0] count_q;
	logic signed [CW-1:0]         out_low_q  [3];
	logic signed [CW-1:0]         out_high_q [3];
	logic        [CW-1:0]         out_rad_q;
	logic        [POOL_BITS-1:0]  out_first_q;
	logic        [POOL_BITS-1:0]  out_acc_q;
	logic                         out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_first_q <= start_q;
			out_last_q  <= last_s1;
			if (admit) begin
				count_q   <= fill_n;
				out_acc_q <= acc_n;
				out_rad_q <= radius_n;
				for (int a = 0; a < 3; a++) begin
					out_low_q[a]  <= low_n[a];
					out_high_q[a] <= high_n[a];
				end
			end else begin
				count_q   <= fill_q;
				out_acc_q <= acc_q;
				out_rad_q <= radius_q;
				for (int a = 0; a < 3; a++) begin
					out_low_q[a]  <= low_q[a];
					out_high_q[a] <= high_q[a];
				end
			end
		end
	end

	// coordinates sign-extended, radius zero-extended back to field width
	assign tiles.valid          = out_valid_q;
	assign tiles.tile_first     = out_first_q;
	assign tiles.tile_count     = count_q;
	assign tiles.low_x          = FW'(out_low_q[0]);
	assign tiles.low_y          = FW'(out_low_q[1]);
	assign tiles.low_z          = FW'(out_low_q[2]);
	assign tiles.high_x         = FW'(out_high_q[0]);
	assign tiles.high_y         = FW'(out_high_q[1]);
	assign tiles.high_z         = FW'(out_high_q[2]);
	assign tiles.radius_max     = FW'(out_rad_q);
	assign tiles.last_tile      = out_last_q;
	assign tiles.accepted_total = out_acc_q;

`ifndef SYNTHESIS
	// both stages occupied with a stalled sink must hold off the source
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !tiles.ready) |-> !particles.ready)
		else $error("input taken while both stages are blocked");

	// the end of a stream leaves no open tile and a cleared counter
	a_stream_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (fill_q == '0 && acc_q == '0 && start_q == '0))
		else $error("tile state not cleared after last particle");

	// a record never describes an empty tile
	a_nonempty_tile: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q != '0))
		else $error("tile record with zero count");
`endif

endmodule

### design/tbb_box_update.sv
// tbb_box_update: running min/max of one axis of a tile bounding box
// no dependencies

module tbb_box_update #(
	parameter int W = 32
) (
	input  logic                first,
	input  logic signed [W-1:0] pos,
	input  logic signed [W-1:0] low,
	input  logic signed [W-1:0] high,
	output logic signed [W-1:0] low_next,
	output logic signed [W-1:0] high_next
);
	// first particle of a tile opens the box at its own position
	assign low_next  = (first || pos < low)  ? pos : low;
	assign high_next = (first || high < pos) ? pos : high;
endmodule

### test/tb.sv
// tb: self-checking testbench for tile_bounding_box_builder_core
// depends on tbb_pkg, tbb_particle_if, tbb_tile_if and the core with its submodules

module tb;

	localparam int CLK_PERIOD   = 12;
	localparam int POOL_W       = 24;
	localparam int COUNT_W      = 16;
	localparam int DRAIN_CYCLES = 8;     // drain margin after the last owed record
	localparam int TYPE_W       = tbb_pkg::TYPE_BITS;
	localparam int FIELD_W      = tbb_pkg::FIELD_BITS;
	localparam int MASK_W       = tbb_pkg::MASK_BITS;
	localparam int SIZE_W       = tbb_pkg::SIZE_BITS;
	localparam int IDX_W        = tbb_pkg::CFG_INDEX_BITS;
	localparam int CFG_W        = tbb_pkg::CFG_DATA_BITS;

	// one particle as it goes over the input channel
	typedef struct packed {
		logic [TYPE_W-1:0]  ptype;
		logic [FIELD_W-1:0] mass;
		logic [FIELD_W-1:0] px;
		logic [FIELD_W-1:0] py;
		logic [FIELD_W-1:0] pz;
		logic [FIELD_W-1:0] radius;
		logic               last;
	} particle_t;

	// one tile record as it comes off the output channel
	typedef struct packed {
		logic [POOL_W-1:0]  first;
		logic [COUNT_W-1:0] count;
		logic [FIELD_W-1:0] lo_x;
		logic [FIELD_W-1:0] lo_y;
		logic [FIELD_W-1:0] lo_z;
		logic [FIELD_W-1:0] hi_x;
		logic [FIELD_W-1:0] hi_y;
		logic [FIELD_W-1:0] hi_z;
		logic [FIELD_W-1:0] radius;
		logic               last;
		logic [POOL_W-1:0]  total;
	} tile_rec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	tbb_particle_if particle_ch ();
	tbb_tile_if #(.POOL_BITS(POOL_W), .COUNT_BITS(COUNT_W)) tile_ch ();

	tile_bounding_box_builder_core #(
		.COORD_BITS(FIELD_W),
		.COUNT_BITS(COUNT_W),
		.POOL_BITS (POOL_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.particles(particle_ch),
		.tiles    (tile_ch)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// idling knobs, in percent of cycles
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	int mismatch_count = 0;
	int sent_count     = 0;

	// tile records still owed by the block, oldest first
	tile_rec_t pending_tiles[$];

	// shadow of the configuration registers
	logic [MASK_W-1:0] shadow_mask;
	logic [SIZE_W-1:0] shadow_size;

	// shadow of the open tile and the stream counters
	logic [POOL_W-1:0]         run_total;
	logic [POOL_W-1:0]         tile_base;
	logic [COUNT_W-1:0]        tile_fill;
	logic signed [FIELD_W-1:0] box_lo [3];
	logic signed [FIELD_W-1:0] box_hi [3];
	logic [FIELD_W-1:0]        radius_peak;

	// ------------------------------------------------------------------
	// tile predictor
	// ------------------------------------------------------------------

	function automatic tile_rec_t snapshot_tile(input logic closes);
		tile_rec_t r;
		r.first  = tile_base;
		r.count  = tile_fill;
		r.lo_x   = box_lo[0];
		r.lo_y   = box_lo[1];
		r.lo_z   = box_lo[2];
		r.hi_x   = box_hi[0];
		r.hi_y   = box_hi[1];
		r.hi_z   = box_hi[2];
		r.radius = radius_peak;
		r.last   = closes;
		r.total  = run_total;
		return r;
	endfunction

	// folds one transferred particle into the open tile, queues any record it closes
	function automatic void fold_particle(input particle_t p);
		logic [SIZE_W-1:0]         size;
		logic                      admit;
		logic                      closed;
		logic signed [FIELD_W-1:0] pos [3];
		size   = (shadow_size == '0) ? SIZE_W'(1) : shadow_size;
		admit  = (p.ptype < tbb_pkg::TYPE_COUNT) && shadow_mask[p.ptype] &&
			!p.mass[FIELD_W-1] && (p.mass != '0);
		closed = 1'b0;
		pos[0] = p.px;
		pos[1] = p.py;
		pos[2] = p.pz;
		if (admit) begin
			// first particle of a tile seeds the box, later ones widen it
			if (tile_fill == '0) begin
				for (int k = 0; k < 3; k++) begin
					box_lo[k] = pos[k];
					box_hi[k] = pos[k];
				end
				radius_peak = p.radius;
			end else begin
				for (int k = 0; k < 3; k++) begin
					if (pos[k] < box_lo[k]) box_lo[k] = pos[k];
					if (pos[k] > box_hi[k]) box_hi[k] = pos[k];
				end
				if (p.radius > radius_peak) radius_peak = p.radius;
			end
			tile_fill = tile_fill + COUNT_W'(1);
			if (run_total != {POOL_W{1'b1}}) run_total = run_total + POOL_W'(1);
			if (tile_fill >= size) begin
				pending_tiles.push_back(snapshot_tile(p.last));
				tile_base = tile_base + POOL_W'(tile_fill);
				tile_fill = '0;
				closed    = 1'b1;
			end
		end
		// end of stream flushes a partial tile and clears the counters
		if (p.last) begin
			if (!closed && tile_fill != '0) pending_tiles.push_back(snapshot_tile(1'b1));
			run_total   = '0;
			tile_base   = '0;
			tile_fill   = '0;
			radius_peak = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one particle transfer, with random idle cycles ahead of it
	task automatic send_particle(input particle_t p);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			particle_ch.valid = 1'b0;
			@(negedge clk);
		end
		particle_ch.valid         = 1'b1;
		particle_ch.particle_type = p.ptype;
		particle_ch.particle_mass = p.mass;
		particle_ch.position_x    = p.px;
		particle_ch.position_y    = p.py;
		particle_ch.position_z    = p.pz;
		particle_ch.kernel_radius = p.radius;
		particle_ch.last_particle = p.last;
		do @(posedge clk); while (!particle_ch.ready);
		fold_particle(p);
		sent_count++;
	endtask

	// stop sending, wait for every owed record, then let the pipeline empty
	task automatic settle_block();
		@(negedge clk);
		particle_ch.valid = 1'b0;
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == tbb_pkg::CFG_TYPE_MASK) shadow_mask = value[MASK_W-1:0];
		else shadow_size = value[SIZE_W-1:0];
	endtask

	function automatic particle_t make_particle(input int ptype, input logic [31:0] mass,
		input logic [31:0] px, py, pz, radius, input logic last);
		particle_t p;
		p.ptype  = ptype[TYPE_W-1:0];
		p.mass   = mass;
		p.px     = px;
		p.py     = py;
		p.pz     = pz;
		p.radius = radius;
		p.last   = last;
		return p;
	endfunction

	// mostly ordinary coordinates, some near zero, a few at the range ends
	function automatic logic [31:0] random_coord();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2, 3, 4: begin
				v = $urandom_range(4095);
				v = v - 32'd2048;
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic particle_t random_particle(input logic last);
		particle_t p;
		// mostly admissible types, the unmapped ones now and then
		p.ptype = ($urandom_range(15) < 14)
			? TYPE_W'($urandom_range(tbb_pkg::TYPE_COUNT - 1))
			: TYPE_W'($urandom_range(7));
		case ($urandom_range(19))
			0: p.mass = '0;
			1: p.mass = $urandom() | 32'h8000_0000;
			2: p.mass = 32'h7fff_ffff;
			3: p.mass = 32'd1;
			default: p.mass = $urandom() & 32'h7fff_ffff;
		endcase
		p.px = random_coord();
		p.py = random_coord();
		p.pz = random_coord();
		case ($urandom_range(9))
			0: p.radius = '0;
			1: p.radius = 32'hffff_ffff;
			default: p.radius = $urandom();
		endcase
		p.last = last;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// receiver and record checker
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		tile_ch.ready = ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic check_field(input string label, input logic [31:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		tile_rec_t want;
		if (arst_n && tile_ch.valid && tile_ch.ready) begin
			if (pending_tiles.size() == 0) begin
				$display("%0t: tile record mismatch, expected none, actual first %h count %h",
					$time, tile_ch.tile_first, tile_ch.tile_count);
				mismatch_count++;
			end else begin
				want = pending_tiles.pop_front();
				check_field("tile_first",     32'(want.first),  32'(tile_ch.tile_first));
				check_field("tile_count",     32'(want.count),  32'(tile_ch.tile_count));
				check_field("low_x",          want.lo_x,        tile_ch.low_x);
				check_field("low_y",          want.lo_y,        tile_ch.low_y);
				check_field("low_z",          want.lo_z,        tile_ch.low_z);
				check_field("high_x",         want.hi_x,        tile_ch.high_x);
				check_field("high_y",         want.hi_y,        tile_ch.high_y);
				check_field("high_z",         want.hi_z,        tile_ch.high_z);
				check_field("radius_max",     want.radius,      tile_ch.radius_max);
				check_field("last_tile",      32'(want.last),   32'(tile_ch.last_tile));
				check_field("accepted_total", 32'(want.total),  32'(tile_ch.accepted_total));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset values of the registers: a short stream ends in one flagged partial tile
	task automatic test_reset_config();
		for (int i = 0; i < 5; i++)
			send_particle(make_particle(i, 32'd1000 + i, i * 7, -i, 32'd3 << i,
				32'd50 - i, i == 4));
		settle_block();
	endtask

	// unmapped types, zero and negative mass; a dropped last particle after a full tile
	task automatic test_drop_rules();
		write_reg(tbb_pkg::CFG_TYPE_MASK, CFG_W'(63));
		write_reg(tbb_pkg::CFG_TILE_SIZE, CFG_W'(2));
		send_particle(make_particle(6, 32'd100, 1, 2, 3, 4, 1'b0));
		send_particle(make_particle(7, 32'd100, 1, 2, 3, 4, 1'b0));
		send_particle(make_particle(0, 32'd0, 1, 2, 3, 4, 1'b0));
		send_particle(make_particle(1, 32'h8000_0000, 1, 2, 3, 4, 1'b0));
		send_particle(make_particle(2, 32'hffff_ffff, 1, 2, 3, 4, 1'b0));
		send_particle(make_particle(0, 32'd1, 10, -20, 30, 5, 1'b0));
		send_particle(make_particle(5, 32'h7fff_ffff, -10, 20, -30, 9, 1'b0));
		// full tile already out, this one is dropped and closes the stream
		send_particle(make_particle(7, 32'd5, 0, 0, 0, 0, 1'b1));
		settle_block();
	endtask

	// an empty mask gives an empty stream, a sparse mask admits only its types
	task automatic test_type_mask();
		write_reg(tbb_pkg::CFG_TYPE_MASK, CFG_W'(0));
		send_particle(make_particle(0, 32'd7, 1, 1, 1, 1, 1'b0));
		send_particle(make_particle(5, 32'd7, 2, 2, 2, 2, 1'b1));
		settle_block();
		write_reg(tbb_pkg::CFG_TYPE_MASK, CFG_W'(6'b101010));
		send_particle(make_particle(1, 32'd7, 5, 6, 7, 8, 1'b0));
		send_particle(make_particle(0, 32'd7, 99, 99, 99, 99, 1'b0));
		send_particle(make_particle(3, 32'd7, -5, 60, 0, 3, 1'b1));
		settle_block();
		write_reg(tbb_pkg::CFG_TYPE_MASK, CFG_W'(63));
	endtask

	// range ends of coordinates and radius, tile size zero, exact fill on last, largest size
	task automatic test_extreme_values();
		write_reg(tbb_pkg::CFG_TILE_SIZE, CFG_W'(0));
		send_particle(make_particle(0, 32'd1, 32'h8000_0000, 32'h7fff_ffff, 0,
			32'hffff_ffff, 1'b0));
		send_particle(make_particle(4, 32'd1, 32'h7fff_ffff, 32'h8000_0000, -1, 0, 1'b1));
		settle_block();
		write_reg(tbb_pkg::CFG_TILE_SIZE, CFG_W'(3));
		send_particle(make_particle(2, 32'd9, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 1'b0));
		send_particle(make_particle(3, 32'd9, 32'h8000_0000, -1, 32'h7fff_ffff,
			32'hffff_ffff, 1'b0));
		send_particle(make_particle(1, 32'd9, 0, 32'h7fff_ffff, 1, 32'h8000_0000, 1'b1));
		settle_block();
		write_reg(tbb_pkg::CFG_TILE_SIZE, CFG_W'(16'hffff));
		send_particle(make_particle(5, 32'd3, -7, 8, -9, 12, 1'b0));
		send_particle(make_particle(0, 32'd3, 7, -8, 9, 11, 1'b1));
		settle_block();
	endtask

	// new register values between streams, small tile sizes most of the time
	task automatic pick_config();
		logic [CFG_W-1:0] mask_val;
		logic [CFG_W-1:0] size_val;
		case ($urandom_range(7))
			0:       mask_val = '0;
			1, 2:    mask_val = CFG_W'($urandom_range(63));
			default: mask_val = CFG_W'(63);
		endcase
		case ($urandom_range(19))
			0:       size_val = '0;
			1:       size_val = 16'hffff;
			2:       size_val = CFG_W'($urandom_range(9, 300));
			3:       size_val = CFG_W'(32);
			default: size_val = CFG_W'($urandom_range(1, 8));
		endcase
		settle_block();
		write_reg(tbb_pkg::CFG_TYPE_MASK, mask_val);
		write_reg(tbb_pkg::CFG_TILE_SIZE, size_val);
	endtask

	// back-to-back streams of random particles under one idling setting
	task automatic test_random_streams(input int idle_pct, input int stall_pct,
		input int item_target);
		int start_count;
		int stream_len;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		start_count    = sent_count;
		while (sent_count - start_count < item_target) begin
			if ($urandom_range(3) == 0) pick_config();
			stream_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60)
				: $urandom_range(1, 12);
			for (int i = 0; i < stream_len; i++)
				send_particle(random_particle(i == stream_len - 1));
		end
		settle_block();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		shadow_mask = tbb_pkg::TYPE_MASK_RESET;
		shadow_size = tbb_pkg::TILE_SIZE_RESET;
		run_total   = '0;
		tile_base   = '0;
		tile_fill   = '0;
		radius_peak = '0;
		for (int k = 0; k < 3; k++) begin
			box_lo[k] = '0;
			box_hi[k] = '0;
		end
		particle_ch.valid         = 1'b0;
		particle_ch.particle_type = '0;
		particle_ch.particle_mass = '0;
		particle_ch.position_x    = '0;
		particle_ch.position_y    = '0;
		particle_ch.position_z    = '0;
		particle_ch.kernel_radius = '0;
		particle_ch.last_particle = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_drop_rules();
		test_type_mask();
		test_extreme_values();

		// no idling, sender gaps, receiver stalls, then both
		test_random_streams(0, 0, 480);
		test_random_streams(76, 0, 480);
		test_random_streams(0, 76, 480);
		test_random_streams(20, 20, 480);

		if (pending_tiles.size() != 0) mismatch_count++;
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// generous ceiling on the whole run
	initial begin
		#(CLK_PERIOD * 400000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
design/tbb_pkg.sv
design/tbb_particle_if.sv
design/tbb_tile_if.sv
design/tbb_box_update.sv
design/tile_bounding_box_builder_core.sv
test/tb.sv
